/* sv/d7cc_pkg.sv */
// d7cc_pkg: shared types and constants for the diminished-seventh chord completer.
// Holds the item structs, MIDI status codes, the fixed chord table and the note map slots.
// No dependencies.
package d7cc_pkg;

  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] TYPE_MASK   = 8'hF0;

  localparam int TABLE_SIZE  = 12;
  localparam int CHORD_SLOTS = 16;
  localparam int CHORD_IDX_W = 4;

  // every chord note lies in one of two ranges; only those notes are tracked
  localparam logic [6:0] BASE_LO    = 7'd30;
  localparam logic [6:0] BASE_HI    = 7'd41;
  localparam logic [6:0] UPPER_LO   = 7'd54;
  localparam logic [6:0] UPPER_HI   = 7'd65;
  localparam logic [6:0] UPPER_SLOT = 7'd12;
  localparam int         HELD_SLOTS = 24;
  localparam int         HELD_IDX_W = 5;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_status;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [6:0] base;
    logic [6:0] note_a;
    logic [6:0] note_b;
    logic [6:0] note_c;
    logic [6:0] added;
  } chord_entry_t;

  // result of evaluating one chord against the held-note map
  typedef struct packed {
    logic       has;
    logic       full;
    logic [6:0] added;
  } chord_eval_t;

  // base, three chord notes, added note; spare slots are never visited
  localparam chord_entry_t CHORD_TABLE [CHORD_SLOTS] = '{
    '{7'd37, 7'd61, 7'd64, 7'd58, 7'd67},
    '{7'd32, 7'd56, 7'd59, 7'd65, 7'd62},
    '{7'd39, 7'd63, 7'd54, 7'd60, 7'd69},
    '{7'd34, 7'd58, 7'd61, 7'd55, 7'd64},
    '{7'd41, 7'd65, 7'd56, 7'd62, 7'd59},
    '{7'd36, 7'd60, 7'd63, 7'd57, 7'd66},
    '{7'd31, 7'd55, 7'd58, 7'd64, 7'd61},
    '{7'd38, 7'd62, 7'd65, 7'd59, 7'd68},
    '{7'd33, 7'd57, 7'd60, 7'd54, 7'd63},
    '{7'd40, 7'd64, 7'd55, 7'd61, 7'd70},
    '{7'd35, 7'd59, 7'd62, 7'd56, 7'd65},
    '{7'd30, 7'd54, 7'd57, 7'd63, 7'd60},
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
    '{7'd0,  7'd0,  7'd0,  7'd0,  7'd0}
  };

  function automatic logic note_tracked(input logic [6:0] n);
    return (n >= BASE_LO && n <= BASE_HI) || (n >= UPPER_LO && n <= UPPER_HI);
  endfunction

  // base notes take slots 0..11, upper chord notes 12..23
  function automatic logic [HELD_IDX_W-1:0] note_slot(input logic [6:0] n);
    logic [6:0] off;
    if (n >= BASE_LO && n <= BASE_HI) off = n - BASE_LO;
    else if (n >= UPPER_LO && n <= UPPER_HI) off = n - UPPER_LO + UPPER_SLOT;
    else off = '0;
    return off[HELD_IDX_W-1:0];
  endfunction

endpackage

/* sv/d7cc_chord_eval.sv */
// d7cc_chord_eval: shared compare unit, checks one chord per cycle.
// Looks up the chord table entry and tests membership and completeness.
// Depends on d7cc_pkg.
module d7cc_chord_eval (
  input  logic [d7cc_pkg::CHORD_IDX_W-1:0] chord_idx,
  input  logic [6:0]                       note,
  input  logic [d7cc_pkg::HELD_SLOTS-1:0]  held,
  output d7cc_pkg::chord_eval_t            ev
);
  import d7cc_pkg::*;

  chord_entry_t entry;

  always_comb begin
    entry    = CHORD_TABLE[chord_idx];
    ev.has   = (entry.base == note) || (entry.note_a == note) ||
               (entry.note_b == note) || (entry.note_c == note);
    ev.full  = held[note_slot(entry.base)] && held[note_slot(entry.note_a)] &&
               held[note_slot(entry.note_b)] && held[note_slot(entry.note_c)];
    ev.added = entry.added;
  end

endmodule

/* sv/dim7_chord_completer.sv */
// dim7_chord_completer: top level, sequencer around the shared chord compare unit.
// Depends on d7cc_pkg and d7cc_chord_eval.
//
// Usage:
//   in_*  : one MIDI event per transfer (status, first and second data byte).
//   out_* : result items; last_of_run marks the final result of an input event.
//   cfg_* : one-bit enable register, always ready; write only while idle.
// A note event is taken, the held-note map updated, then the NCH chords are walked
// one per cycle through the compare unit unless the walk is held; NCH = min(NUM_CHORDS, 12).
// The note map keeps only the 24 notes that the chords are built from.
// A found result is held in a pending slot until the next hit or the end of the
// walk, so last_of_run is known when it leaves. in_ready is low while an event is
// in work. A stalled receiver holds the walk when a second result is found while
// the output register is still full; the final result and the passed item also
// wait for the output register to free.
// Disabled: events are taken and dropped at once.
// Reset clears the held-note map, chord flags and output valid, and sets enable.
module dim7_chord_completer #(
  parameter int NUM_CHORDS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  d7cc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output d7cc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import d7cc_pkg::*;

  localparam int NCH = (NUM_CHORDS < TABLE_SIZE) ? NUM_CHORDS : TABLE_SIZE;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(NCH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_PASS  = 3'd3;

  localparam logic [1:0] K_ON   = 2'd0;
  localparam logic [1:0] K_OFF  = 2'd1;
  localparam logic [1:0] K_STOP = 2'd2;
  localparam logic [1:0] K_PASS = 2'd3;

  logic [2:0]            state;
  logic [1:0]            kind;
  logic                  enable;
  logic [HELD_SLOTS-1:0] held;
  logic [NCH-1:0]        active;
  logic [CW-1:0]         cidx;
  in_item_t              item;
  logic                  pend_valid;
  logic [6:0]            pend_note;

  logic [7:0]  in_type;
  logic [6:0]  in_note;
  logic [1:0]  in_kind;
  logic        hit;
  logic        out_free;
  logic        scan_adv;
  logic        load;
  logic [7:0]  res_status;
  chord_eval_t ev;

  d7cc_chord_eval u_eval (
    .chord_idx (CHORD_IDX_W'(cidx)),
    .note      (item.first_data[6:0]),
    .held      (held),
    .ev        (ev)
  );

  always_comb begin
    in_type = in_data.status_byte & TYPE_MASK;
    in_note = in_data.first_data[6:0];
    priority if (in_type == ST_NOTE_ON && in_data.second_data[6:0] != 7'd0) begin
      in_kind = K_ON;
    end else if (in_type == ST_NOTE_ON || in_type == ST_NOTE_OFF) begin
      in_kind = K_OFF;
    end else if (in_type == ST_SYSEX && in_note == 7'd0) begin
      in_kind = K_STOP;
    end else begin
      in_kind = K_PASS;
    end
  end

  always_comb begin
    unique case (kind)
      K_ON:    hit = ev.has && ev.full;
      K_OFF:   hit = active[cidx] && ev.has && !ev.full;
      K_STOP:  hit = active[cidx];
      default: hit = 1'b0;
    endcase
  end

  assign out_free   = !out_valid || out_ready;
  assign scan_adv   = !(hit && pend_valid) || out_free;
  assign res_status = (kind == K_ON) ? ST_NOTE_ON : ST_NOTE_OFF;
  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  // output register loads this cycle
  always_comb begin
    unique case (state)
      S_SCAN:  load = scan_adv && hit && pend_valid;
      S_FLUSH: load = pend_valid && out_free;
      S_PASS:  load = out_free;
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= K_PASS;
      enable     <= 1'b1;
      held       <= '0;
      active     <= '0;
      cidx       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) enable <= cfg_data;
      out_valid <= load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid && enable) begin
            item       <= in_data;
            kind       <= in_kind;
            cidx       <= '0;
            pend_valid <= 1'b0;
            if (note_tracked(in_note)) begin
              if (in_kind == K_ON) held[note_slot(in_note)] <= 1'b1;
              else if (in_kind == K_OFF) held[note_slot(in_note)] <= 1'b0;
            end
            state <= (in_kind == K_PASS) ? S_PASS : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_adv) begin
            if (hit) begin
              if (pend_valid) begin
                out_data <= '{res_status, {1'b0, pend_note}, item.second_data, 1'b0};
              end
              pend_valid   <= 1'b1;
              pend_note    <= ev.added;
              active[cidx] <= (kind == K_ON);
            end
            if (cidx == LAST_IDX) state <= S_FLUSH;
            else cidx <= cidx + 1'b1;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= (kind == K_STOP) ? S_PASS : S_IDLE;
          end else if (out_free) begin
            out_data   <= '{res_status, {1'b0, pend_note}, item.second_data,
                            (kind != K_STOP)};
            pend_valid <= 1'b0;
            state      <= (kind == K_STOP) ? S_PASS : S_IDLE;
          end
        end
        S_PASS: begin
          if (out_free) begin
            out_data  <= '{item.status_byte & TYPE_MASK, item.first_data,
                           item.second_data, 1'b1};
            if (kind == K_STOP) begin
              held   <= '0;
              active <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the pending slot is always drained before a new event is taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending result left over in idle");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cidx <= LAST_IDX))
    else $error("chord index beyond table");

  // a stop leaves every note and flag clear
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS && out_free && kind == K_STOP) |=> (held == '0 && active == '0))
    else $error("stop did not clear state");

  // only the passed item of a stop may end a stop run
  a_stop_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && kind == K_STOP && pend_valid && out_free)
      |=> (out_valid && !out_data.last_of_run))
    else $error("stop note-off flagged as last");

endmodule
